// ----- rtl/core/kicker_pulse_and_ball_sensor_unit_macros.svh -----
// Assertion macros shared by the kicker and ball sensor RTL.
`ifndef KICKER_PULSE_AND_BALL_SENSOR_UNIT_MACROS_SVH
`define KICKER_PULSE_AND_BALL_SENSOR_UNIT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define KPBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define KPBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/kpbs_pkg.sv -----
// Types, codes and reset values of the kicker and ball sensor unit.
package kpbs_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_KICK_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_FULL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LOW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BALL_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BALL_CEILING   = 3'd5;

  localparam logic        RST_KICK_ENABLE    = 1'b1;
  localparam logic [15:0] RST_PULSE_FULL     = 16'd20;
  localparam logic [15:0] RST_PULSE_LOW      = 16'd5;
  localparam logic [15:0] RST_COOLDOWN_TICKS = 16'd1000;
  localparam logic [15:0] RST_BALL_THRESHOLD = 16'd10;
  localparam logic [15:0] RST_BALL_CEILING   = 16'd30;

  typedef enum logic [1:0] {
    KIND_TICK      = 2'd0,
    KIND_KICK_FULL = 2'd1,
    KIND_KICK_LOW  = 2'd2,
    KIND_SAMPLE    = 2'd3
  } kind_t;

  typedef struct packed {
    logic        kick_enable;
    logic [15:0] pulse_full;
    logic [15:0] pulse_low;
    logic [15:0] cooldown_ticks;
    logic [15:0] ball_threshold;
    logic [15:0] ball_ceiling;
  } cfg_t;

  typedef struct packed {
    logic solenoid_drive;
    logic kicker_ready;
    logic ball_present;
  } status_t;

endpackage

// ----- rtl/core/kpbs_in_if.sv -----
// Event channel into the kicker and ball sensor unit.
interface kpbs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       beam_blocked;

  modport source (output valid, output kind, output beam_blocked, input ready);
  modport sink (input valid, input kind, input beam_blocked, output ready);
endinterface

// ----- rtl/core/kpbs_out_if.sv -----
// Status channel out of the kicker and ball sensor unit.
interface kpbs_out_if;
  logic valid;
  logic ready;
  logic solenoid_drive;
  logic kicker_ready;
  logic ball_present;

  modport source (output valid, output solenoid_drive, output kicker_ready,
                  output ball_present, input ready);
  modport sink (input valid, input solenoid_drive, input kicker_ready,
                input ball_present, output ready);
endinterface

// ----- rtl/core/kpbs_regs.sv -----
// Configuration register file of the kicker and ball sensor unit.
module kpbs_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [kpbs_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [kpbs_pkg::CFG_DATA_W-1:0]     cfg_data,
  output kpbs_pkg::cfg_t                      cfg
);

  kpbs_pkg::cfg_t cfg_r;
  kpbs_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        kpbs_pkg::CFG_KICK_ENABLE:    cfg_nxt.kick_enable    = cfg_data[0];
        kpbs_pkg::CFG_PULSE_FULL:     cfg_nxt.pulse_full     = cfg_data;
        kpbs_pkg::CFG_PULSE_LOW:      cfg_nxt.pulse_low      = cfg_data;
        kpbs_pkg::CFG_COOLDOWN_TICKS: cfg_nxt.cooldown_ticks = cfg_data;
        kpbs_pkg::CFG_BALL_THRESHOLD: cfg_nxt.ball_threshold = cfg_data;
        kpbs_pkg::CFG_BALL_CEILING:   cfg_nxt.ball_ceiling   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kick_enable    <= kpbs_pkg::RST_KICK_ENABLE;
      cfg_r.pulse_full     <= kpbs_pkg::RST_PULSE_FULL;
      cfg_r.pulse_low      <= kpbs_pkg::RST_PULSE_LOW;
      cfg_r.cooldown_ticks <= kpbs_pkg::RST_COOLDOWN_TICKS;
      cfg_r.ball_threshold <= kpbs_pkg::RST_BALL_THRESHOLD;
      cfg_r.ball_ceiling   <= kpbs_pkg::RST_BALL_CEILING;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/kpbs_core.sv -----
// Kicker pulse, cooldown and ball integrator state with its event update.
`include "kicker_pulse_and_ball_sensor_unit_macros.svh"

module kpbs_core (
  input  logic                clk,
  input  logic                rst_n,
  input  kpbs_pkg::cfg_t      cfg,
  input  logic                take,
  input  logic [1:0]          kind,
  input  logic                beam_blocked,
  output kpbs_pkg::status_t   status_nxt
);

  logic        ready_r, ready_nxt;
  logic [15:0] cooldown_r, cooldown_nxt;
  logic [15:0] pulse_r, pulse_nxt;
  logic        drive_r, drive_nxt;
  logic [15:0] integ_r, integ_nxt;
  logic        present_r, present_nxt;

  logic [15:0] cooldown_inc;
  logic        cooled;
  logic        above;
  logic        kick_ok;

  assign cooldown_inc = cooldown_r + 16'd1;
  assign cooled       = !ready_r && (cooldown_inc > cfg.cooldown_ticks);
  assign above        = integ_r > cfg.ball_threshold;
  assign kick_ok      = cfg.kick_enable && ready_r;

  always_comb begin
    ready_nxt    = ready_r;
    cooldown_nxt = cooldown_r;
    pulse_nxt    = pulse_r;
    drive_nxt    = drive_r;
    integ_nxt    = integ_r;
    present_nxt  = present_r;
    unique case (kpbs_pkg::kind_t'(kind))
      kpbs_pkg::KIND_TICK: begin
        if (!ready_r) begin
          cooldown_nxt = cooldown_inc;
        end
        if (cooled) begin
          drive_nxt    = 1'b0;
          cooldown_nxt = 16'd0;
          ready_nxt    = 1'b1;
        end else if (pulse_r != 16'd0) begin
          pulse_nxt = pulse_r - 16'd1;
          drive_nxt = 1'b1;
        end else begin
          drive_nxt = 1'b0;
        end
      end
      kpbs_pkg::KIND_KICK_FULL, kpbs_pkg::KIND_KICK_LOW: begin
        if (kick_ok) begin
          pulse_nxt = (kpbs_pkg::kind_t'(kind) == kpbs_pkg::KIND_KICK_FULL) ?
                      cfg.pulse_full : cfg.pulse_low;
          integ_nxt = 16'd0;
          ready_nxt = 1'b0;
        end
      end
      kpbs_pkg::KIND_SAMPLE: begin
        present_nxt = above;
        if (beam_blocked) begin
          if (above) begin
            if (integ_r < cfg.ball_ceiling) begin
              integ_nxt = integ_r + 16'd1;
            end
          end else if (integ_r != 16'hFFFF) begin
            integ_nxt = integ_r + 16'd1;
          end
        end else if (integ_r != 16'd0) begin
          integ_nxt = integ_r - 16'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r    <= 1'b1;
      cooldown_r <= 16'd0;
      pulse_r    <= 16'd0;
      drive_r    <= 1'b0;
      integ_r    <= 16'd0;
      present_r  <= 1'b0;
    end else if (take) begin
      ready_r    <= ready_nxt;
      cooldown_r <= cooldown_nxt;
      pulse_r    <= pulse_nxt;
      drive_r    <= drive_nxt;
      integ_r    <= integ_nxt;
      present_r  <= present_nxt;
    end
  end

  assign status_nxt.solenoid_drive = drive_nxt;
  assign status_nxt.kicker_ready   = ready_nxt;
  assign status_nxt.ball_present   = present_nxt;

  // A ready kicker never carries a partial cooldown.
  `KPBS_ASSERT(a_ready_no_cooldown, ready_r |-> (cooldown_r == 16'd0), "cooldown left while ready")
  `KPBS_ASSERT(a_kick_starts_cooldown, (take && ready_r && cfg.kick_enable && (kind == kpbs_pkg::KIND_KICK_FULL || kind == kpbs_pkg::KIND_KICK_LOW)) |=> (!ready_r && integ_r == 16'd0), "accepted kick did not start cooldown")
  `KPBS_ASSERT(a_clear_sample_decays, (take && kind == kpbs_pkg::KIND_SAMPLE && !beam_blocked && integ_r != 16'd0) |=> (integ_r == $past(integ_r) - 16'd1), "clear sample did not decay integrator")

endmodule

// ----- rtl/core/kicker_pulse_and_ball_sensor_unit.sv -----
// Top level of the kicker pulse controller and ball sensor qualifier.
// Every accepted event word (tick, full kick, low kick, sensor sample) yields one status
// word in the cycle after acceptance that shows the solenoid level, kicker readiness and ball
// presence after that event. An event is taken every cycle unless the output stalls: the state
// counters update in the cycle of acceptance and the status lands in an output register, so
// throughput is one word per cycle while the sink keeps up; in_ch.ready drops only while a
// status word waits and the sink stalls. Configuration writes take effect on the next cycle.
`include "kicker_pulse_and_ball_sensor_unit_macros.svh"

module kicker_pulse_and_ball_sensor_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  kpbs_in_if.sink                          in_ch,
  kpbs_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [kpbs_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [kpbs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  kpbs_pkg::cfg_t    cfg;
  kpbs_pkg::status_t status_nxt;
  kpbs_pkg::status_t res_r;
  logic              out_valid_r;
  logic              take;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  kpbs_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  kpbs_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .take         (take),
    .kind         (in_ch.kind),
    .beam_blocked (in_ch.beam_blocked),
    .status_nxt   (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= status_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.solenoid_drive = res_r.solenoid_drive;
  assign out_ch.kicker_ready   = res_r.kicker_ready;
  assign out_ch.ball_present   = res_r.ball_present;

  `KPBS_ASSERT(a_take_gives_word, take |=> out_valid_r, "accepted event produced no status word")
  `KPBS_ASSERT(a_stall_keeps_word, (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(res_r)), "stalled status word was lost")
  `KPBS_ASSERT_ALWAYS(a_reset_clears_valid, !rst_n |=> !out_valid_r, "status valid not cleared by reset")

endmodule
